/* src/hps_pkg.sv */
// Shared types, constants and helpers for the Horspool pattern search block.
// No dependencies.
package hps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_CAP     = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 32;
    localparam int WIN_IDX_W   = $clog2(PATTERN_MAX);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [LEN_W-1:0]               len;
        logic                           reload;
        logic [PAT_BYTES-1:0][7:0]      pat;
    } t_cfg;

    typedef struct packed {
        logic             match_end;
        logic [CNT_W-1:0] compare_total;
        logic [CNT_W-1:0] match_total;
    } t_result;

    // raw length -> length in use: zero taken as one, capped at PAT_CAP
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] n;
        n = raw;
        if (raw == '0) begin
            n = LEN_W'(1);
        end else if (int'(raw) > PAT_CAP) begin
            n = LEN_W'(PAT_CAP);
        end
        return n;
    endfunction

endpackage

/* src/hps_if.sv */
// Stream interfaces for text beats in and result beats out.
// Depends on hps_pkg.
interface hps_in_if
    import hps_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface hps_out_if
    import hps_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             match_end;
    logic [CNT_W-1:0] compare_total;
    logic [CNT_W-1:0] match_total;
    logic             text_done;

    modport source (output valid, output match_end, output compare_total,
                    output match_total, output text_done, input ready);
    modport sink   (input valid, input match_end, input compare_total,
                    input match_total, input text_done, output ready);
endinterface

/* src/hps_cfg.sv */
// Configuration registers: pattern length and the sixteen pattern bytes.
// Depends on hps_pkg.
module hps_cfg
    import hps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [LEN_W-1:0]      r_len;
    logic [CFG_DATA_W-1:0] r_low;
    logic [CFG_DATA_W-1:0] r_high;
    logic                  r_reload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(1);
            r_low    <= '0;
            r_high   <= '0;
            r_reload <= 1'b0;
        end else begin
            r_reload <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PATTERN_LENGTH: begin
                        r_len    <= i_cfg_data[LEN_W-1:0];
                        r_reload <= 1'b1;
                    end
                    REG_PATTERN_LOW:  r_low  <= i_cfg_data;
                    REG_PATTERN_HIGH: r_high <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg.len    = eff_len(r_len);
    assign o_cfg.reload = r_reload;
    assign o_cfg.pat    = {r_high, r_low};

endmodule

/* src/hps_core.sv */
// Search state (window, check countdown, counters) and the per-byte check logic.
// Depends on hps_pkg.
module hps_core
    import hps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_result
);

    logic [PATTERN_MAX-1:0][7:0] r_win;
    logic [LEN_W-1:0]            r_countdown;
    logic [CNT_W-1:0]            r_cmp_cnt;
    logic [CNT_W-1:0]            r_match_cnt;

    logic [PATTERN_MAX-1:0][7:0] n_win;
    logic [LEN_W-1:0]            n_countdown;
    logic [CNT_W-1:0]            n_cmp_cnt;
    logic [CNT_W-1:0]            n_match_cnt;

    logic [LEN_W-1:0] len;
    logic             check;
    logic             mis;
    logic [LEN_W-1:0] mis_j;
    logic [LEN_W-1:0] cmps;
    logic [LEN_W-1:0] skip;
    logic [LEN_W-1:0] pos;
    logic [CNT_W:0]   cmp_sum;
    logic [CNT_W:0]   match_sum;
    logic             matched;

    assign len   = i_cfg.len;
    assign n_win = {r_win[PATTERN_MAX-2:0], i_byte};
    assign check = (r_countdown == '0);

    // right-to-left compare; the highest mismatching pattern index stops the scan
    always_comb begin
        mis   = 1'b0;
        mis_j = '0;
        pos   = '0;
        for (int j = 0; j < PAT_CAP; j++) begin
            pos = len - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < len && n_win[WIN_IDX_W'(pos)] != i_cfg.pat[j]) begin
                mis   = 1'b1;
                mis_j = LEN_W'(j);
            end
        end
        cmps    = mis ? (len - mis_j) : len;
        matched = check && !mis;
    end

    // Horspool skip from the newest byte over pattern bytes 0..len-2
    always_comb begin
        skip = len;
        for (int k = 0; k < PAT_CAP - 1; k++) begin
            if (LEN_W'(k) + LEN_W'(1) < len && i_cfg.pat[k] == i_byte) begin
                skip = len - LEN_W'(1) - LEN_W'(k);
            end
        end
    end

    always_comb begin
        cmp_sum   = {1'b0, r_cmp_cnt} + (CNT_W+1)'(cmps);
        match_sum = {1'b0, r_match_cnt} + (CNT_W+1)'(1);
        n_cmp_cnt   = r_cmp_cnt;
        n_match_cnt = r_match_cnt;
        if (check) begin
            n_cmp_cnt   = cmp_sum[CNT_W] ? '1 : cmp_sum[CNT_W-1:0];
            n_countdown = skip - LEN_W'(1);
            if (matched) begin
                n_match_cnt = match_sum[CNT_W] ? '1 : match_sum[CNT_W-1:0];
            end
        end else begin
            n_countdown = r_countdown - LEN_W'(1);
        end
    end

    assign o_result.match_end     = matched;
    assign o_result.compare_total = n_cmp_cnt;
    assign o_result.match_total   = n_match_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_countdown <= eff_len(LEN_W'(1)) - LEN_W'(1);
            r_cmp_cnt   <= '0;
            r_match_cnt <= '0;
        end else if (i_cfg.reload) begin
            r_countdown <= len - LEN_W'(1);
        end else if (i_fire) begin
            if (i_last) begin
                r_win       <= '0;
                r_countdown <= len - LEN_W'(1);
                r_cmp_cnt   <= '0;
                r_match_cnt <= '0;
            end else begin
                r_win       <= n_win;
                r_countdown <= n_countdown;
                r_cmp_cnt   <= n_cmp_cnt;
                r_match_cnt <= n_match_cnt;
            end
        end
    end

endmodule

/* src/horspool_pattern_search.sv */
// Streaming Horspool pattern search: one text byte in, one result beat out.
// Path from input beat to result beat: input register, then check + result register.
// Accepts one beat per cycle; stalls only when the result register is held by o_out.ready.
// Reset (synchronous, i_rst_n low): length 1, pattern zero, window and counters cleared.
// Depends on hps_pkg, hps_if, hps_cfg, hps_core.
module horspool_pattern_search
    import hps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hps_in_if.sink                i_in,
    hps_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result result;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       r_out_valid;
    t_result    r_out;
    logic       r_out_done;

    logic out_free;
    logic fire;
    logic in_ready;

    assign out_free = !r_out_valid || o_out.ready;
    assign fire     = r_in_valid && out_free;
    assign in_ready = !r_in_valid || fire;

    hps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_byte <= i_in.text_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out      <= result;
            r_out_done <= r_in_last;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.match_end     = r_out.match_end;
    assign o_out.compare_total = r_out.compare_total;
    assign o_out.match_total   = r_out.match_total;
    assign o_out.text_done     = r_out_done;

endmodule
